>>> hdl/base58_block_encoder_core_defines.svh
// Assertion helpers shared by the encoder RTL.
`ifndef BASE58_BLOCK_ENCODER_CORE_DEFINES_SVH
`define BASE58_BLOCK_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define B58E_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define B58E_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/b58e_pkg.sv
package b58e_pkg;

    localparam int BLOCK_BYTES = 8;
    localparam int BLOCK_CHARS = 11;
    localparam int RADIX       = 58;
    localparam int SYMS        = 58;

    localparam logic [SYMS*8-1:0] ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } b58e_in_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       end_of_text;
    } b58e_out_t;

    // Characters produced by a block of the given byte length.
    function automatic logic [3:0] chars_for_len(input logic [3:0] len);
        logic [3:0] n;
        begin
            case (len)
                4'd1: n = 4'd2;
                4'd2: n = 4'd3;
                4'd3: n = 4'd5;
                4'd4: n = 4'd6;
                4'd5: n = 4'd7;
                4'd6: n = 4'd9;
                4'd7: n = 4'd10;
                4'd8: n = 4'd11;
                default: n = 4'd0;
            endcase
            return n;
        end
    endfunction

    // Map a digit to its ASCII symbol; out-of-range digits map to the first symbol.
    function automatic logic [6:0] b58_char(input logic [5:0] d);
        logic [7:0] c;
        begin
            if (int'(d) >= SYMS) begin
                c = ALPHABET[SYMS*8-1 -: 8];
            end else begin
                c = ALPHABET[(SYMS-1-int'(d))*8 +: 8];
            end
            return c[6:0];
        end
    endfunction

endpackage

>>> hdl/b58e_div_step.sv
// Divide one byte of the dividend by 58, carrying in the running remainder.
module b58e_div_step (
    input  logic [5:0] rem_in,
    input  logic [7:0] byte_in,
    output logic [7:0] quo_out,
    output logic [5:0] rem_out
);
    import b58e_pkg::*;

    localparam logic [6:0] DIVISOR = 7'(RADIX);

    always_comb begin
        logic [6:0] r;
        r = {1'b0, rem_in};
        quo_out = '0;
        for (int i = 7; i >= 0; i--) begin
            r = {r[5:0], byte_in[i]};
            if (r >= DIVISOR) begin
                r = r - DIVISOR;
                quo_out[i] = 1'b1;
            end
        end
        rem_out = r[5:0];
    end

endmodule

>>> hdl/base58_block_encoder_core.sv
// Block base58 encoder. Bytes enter one per accepted item and are packed
// big-endian into a 64-bit block. A byte that does not close the block is
// taken and the core stays ready. A block closes on its eighth byte or on a
// byte with is_last set; the core then drops s_ready and divides the block
// by 58 with one shared byte-wide divide step, one dividend byte per step and
// one digit per pass over the block, then sends the characters out, one
// character per cycle while m_ready stays high. A full block gives 11
// characters, a final partial block of 1 to 7 bytes gives 2, 3, 5, 6, 7, 9
// or 10. Characters leave most significant digit first as ASCII codes of the
// base58 alphabet; end_of_text marks the last character of a message. The
// output register lets the core take the next input byte while the final
// character waits.
`include "base58_block_encoder_core_defines.svh"

module base58_block_encoder_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b58e_pkg::b58e_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output b58e_pkg::b58e_out_t m_item
);
    import b58e_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [63:0] val_reg, val_next;
    logic [2:0]  nbytes_reg, nbytes_next;
    logic [5:0]  rem_reg, rem_next;
    logic [2:0]  step_reg, step_next;
    logic [3:0]  dig_idx_reg, dig_idx_next;
    logic [3:0]  count_reg, count_next;
    logic [3:0]  emit_idx_reg, emit_idx_next;
    logic        last_reg, last_next;
    logic        m_valid_reg, m_valid_next;
    b58e_out_t   m_item_reg, m_item_next;

    logic [5:0]  digit_store [BLOCK_CHARS];

    logic        s_fire;
    logic [3:0]  len;
    logic        closing;
    logic [7:0]  step_quo;
    logic [5:0]  step_rem;
    logic        digit_done;
    logic        out_free;

    b58e_div_step u_div_step (
        .rem_in  (rem_reg),
        .byte_in (val_reg[63:56]),
        .quo_out (step_quo),
        .rem_out (step_rem)
    );

    assign s_ready    = (state_reg == S_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign len        = {1'b0, nbytes_reg} + 4'd1;
    assign closing    = (len == 4'(BLOCK_BYTES)) || s_item.is_last;
    assign digit_done = (state_reg == S_DIV) && (step_reg == 3'd7);
    assign out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        state_next    = state_reg;
        val_next      = val_reg;
        nbytes_next   = nbytes_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        dig_idx_next  = dig_idx_reg;
        count_next    = count_reg;
        emit_idx_next = emit_idx_reg;
        last_next     = last_reg;
        m_valid_next  = m_valid_reg;
        m_item_next   = m_item_reg;

        // Drop the output item once taken; a new load below overrides this.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    val_next = {val_reg[55:0], s_item.data_byte};
                    if (closing) begin
                        // Block closes: start dividing from the top byte.
                        nbytes_next  = '0;
                        count_next   = chars_for_len(len);
                        dig_idx_next = chars_for_len(len) - 4'd1;
                        last_next    = s_item.is_last;
                        rem_next     = '0;
                        step_next    = '0;
                        state_next   = S_DIV;
                    end else begin
                        nbytes_next = len[2:0];
                    end
                end
            end
            S_DIV: begin
                // Shift the quotient in as the dividend shifts out.
                val_next  = {val_reg[55:0], step_quo};
                step_next = step_reg + 3'd1;
                if (digit_done) begin
                    rem_next = '0;
                    if (dig_idx_reg == '0) begin
                        emit_idx_next = '0;
                        state_next    = S_EMIT;
                    end else begin
                        dig_idx_next = dig_idx_reg - 4'd1;
                    end
                end else begin
                    rem_next = step_rem;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_item_next.out_char    = b58_char(digit_store[emit_idx_reg]);
                    m_item_next.end_of_text = last_reg && (emit_idx_reg == count_reg - 4'd1);
                    emit_idx_next           = emit_idx_reg + 4'd1;
                    if (emit_idx_reg == count_reg - 4'd1) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            val_reg     <= '0;
            nbytes_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            val_reg     <= val_next;
            nbytes_reg  <= nbytes_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        dig_idx_reg  <= dig_idx_next;
        count_reg    <= count_next;
        emit_idx_reg <= emit_idx_next;
        last_reg     <= last_next;
        m_item_reg   <= m_item_next;
    end

    // Hold each finished digit at its place, least significant last.
    always_ff @(posedge aclk) begin
        if (digit_done) begin
            digit_store[dig_idx_reg] <= step_rem;
        end
    end

    `B58E_ASSERT_NOW(a_rem_below_radix, aclk, aresetn, state_reg == S_DIV,
        rem_reg < 6'(RADIX), "remainder left the radix range")
    `B58E_ASSERT_NOW(a_quotient_spent, aclk, aresetn, state_reg == S_EMIT,
        val_reg == '0, "block value not fully consumed by the digit count")
    `B58E_ASSERT_NEXT(a_close_starts_div, aclk, aresetn, s_fire && closing,
        state_reg == S_DIV && step_reg == '0 && nbytes_reg == '0, "closed block did not start division")
    `B58E_ASSERT_NOW(a_emit_in_range, aclk, aresetn, state_reg == S_EMIT,
        emit_idx_reg < count_reg, "emit index past digit count")

endmodule

>>> tb/base58_block_encoder_core_test.sv
module base58_block_encoder_core_test;

    import b58e_pkg::b58e_in_t;
    import b58e_pkg::b58e_out_t;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int BYTES_PER_BLK = 8;
    localparam int CHARS_PER_BLK = 11;
    localparam int NUM_PHASES    = 3;
    localparam int PHASE_ITEMS   = 143;
    localparam int MAX_MSG_LEN   = 20;
    // Full block: division of all 11 digits plus 11 characters out, with margin.
    localparam int DRAIN_CYCLES  = 8 * CHARS_PER_BLK + CHARS_PER_BLK + 20;
    localparam int CYCLE_LIMIT   = 400000;

    localparam string SYMBOLS =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef struct {
        logic [7:0] data;
        bit         last;
        string      text;   // typed expectation; empty means use the predictor
    } dir_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    b58e_in_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    b58e_out_t m_item;

    int        cycle_count  = 0;
    int        err_count    = 0;
    int        src_idle_pct = 34;
    int        snk_idle_pct = 66;

    // Predictor state: the open block and its byte count.
    logic [63:0] open_block = '0;
    logic [2:0]  open_bytes = '0;
    int          chars_per_len [9] = '{0, 2, 3, 5, 6, 7, 9, 10, 11};

    b58e_out_t   block_chars [$];   // characters of the block just closed
    b58e_out_t   pending_chars [$]; // characters still owed by the core
    b58e_out_t   oldest_char;

    int src_pcts [NUM_PHASES] = '{34, 66, 0};
    int snk_pcts [NUM_PHASES] = '{66, 34, 0};

    dir_row_t dir_rows [22] = '{
        '{8'h00, 1'b1, "11"},
        '{8'hFF, 1'b1, "5Q"},
        '{8'h39, 1'b1, "1z"},
        // full block of zeros closed by the last marker
        '{8'h00, 1'b0, ""},
        '{8'h00, 1'b0, ""},
        '{8'h00, 1'b0, ""},
        '{8'h00, 1'b0, ""},
        '{8'h00, 1'b0, ""},
        '{8'h00, 1'b0, ""},
        '{8'h00, 1'b0, ""},
        '{8'h00, 1'b1, "11111111111"},
        // full block of ones, no marker: nothing flagged
        '{8'hFF, 1'b0, ""},
        '{8'hFF, 1'b0, ""},
        '{8'hFF, 1'b0, ""},
        '{8'hFF, 1'b0, ""},
        '{8'hFF, 1'b0, ""},
        '{8'hFF, 1'b0, ""},
        '{8'hFF, 1'b0, ""},
        '{8'hFF, 1'b0, ""},
        // three-byte partial block closed by the marker
        '{8'hA5, 1'b0, ""},
        '{8'h5A, 1'b0, ""},
        '{8'hFF, 1'b1, ""}
    };

    base58_block_encoder_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Fold one byte into the open block; on close, fill block_chars with its text.
    function automatic void encode_byte(input b58e_in_t it);
        int          len;
        int          count;
        logic [63:0] v;
        logic [5:0]  digits [CHARS_PER_BLK];
        byte         sym;
        block_chars.delete();
        len        = int'(open_bytes) + 1;
        open_block = {open_block[55:0], it.data_byte};
        if (len < BYTES_PER_BLK && !it.is_last) begin
            open_bytes = 3'(len);
            return;
        end
        count = (len >= BYTES_PER_BLK) ? CHARS_PER_BLK : chars_per_len[len];
        v = open_block;
        for (int k = count - 1; k >= 0; k--) begin
            digits[k] = 6'(v % 64'd58);
            v         = v / 64'd58;
        end
        for (int k = 0; k < count; k++) begin
            sym = SYMBOLS[digits[k]];
            block_chars.push_back('{out_char: sym[6:0],
                                    end_of_text: it.is_last && (k == count - 1)});
        end
        open_block = '0;
        open_bytes = '0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    // Offer one item, hold it until accepted, then queue what it owes.
    task automatic send_item(input b58e_in_t it, input string text);
        byte ch;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        encode_byte(it);
        if (text.len() == 0) begin
            foreach (block_chars[k]) pending_chars.push_back(block_chars[k]);
        end else begin
            for (int k = 0; k < text.len(); k++) begin
                ch = text[k];
                pending_chars.push_back('{out_char: ch[6:0],
                                          end_of_text: it.is_last && (k == text.len() - 1)});
            end
        end
    endtask

    // Check each character taken from the core against the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("char %0h with nothing pending", m_item.out_char));
            end else begin
                oldest_char = pending_chars.pop_front();
                if (m_item.out_char !== oldest_char.out_char)
                    report_mismatch($sformatf("out_char %0h, want %0h",
                                              m_item.out_char, oldest_char.out_char));
                if (m_item.end_of_text !== oldest_char.end_of_text)
                    report_mismatch($sformatf("end_of_text %0b, want %0b",
                                              m_item.end_of_text, oldest_char.end_of_text));
            end
        end
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        b58e_in_t it;
        int       sent;
        int       len;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows: extremes, one-byte, three-byte and full blocks, flagged and unflagged ends.
        foreach (dir_rows[r]) begin
            it.data_byte = dir_rows[r].data;
            it.is_last   = dir_rows[r].last;
            send_item(it, dir_rows[r].text);
        end

        // Random messages of 1..20 bytes, bytes biased toward the extremes.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            src_idle_pct = src_pcts[ph];
            snk_idle_pct = snk_pcts[ph];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = $urandom_range(1, MAX_MSG_LEN);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(9))
                        0:       it.data_byte = 8'h00;
                        1:       it.data_byte = 8'hFF;
                        default: it.data_byte = 8'($urandom_range(255));
                    endcase
                    it.is_last = (i == len - 1);
                    send_item(it, "");
                end
                sent += len;
            end
        end
        s_valid <= 1'b0;

        // Drain what is owed, then give the core time to misbehave.
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
